@@ sv/kti_pkg.sv @@
// Package: shared constants, types and arithmetic helpers for the keyframe interpolator.
`timescale 1ns / 1ps
package kti_pkg;

  localparam int unsigned MaxKeysDefault = 16;
  localparam int unsigned TimeW          = 32;
  localparam int unsigned ValW           = 16;
  localparam int unsigned FracW          = 17;
  localparam int unsigned CfgAddrW       = 1;
  localparam int unsigned CfgDataW       = 5;

  localparam logic [CfgAddrW-1:0] CfgLoopEnable = 1'b0;
  localparam logic [CfgAddrW-1:0] CfgKeyCount   = 1'b1;

  typedef enum logic [3:0] {
    StIdle,
    StFetch,
    StWrapDiv,
    StWrapFix,
    StSearch,
    StPick,
    StFracDiv,
    StMul,
    StDone
  } kti_state_e;

  typedef struct packed {
    logic signed [TimeW-1:0] t;
    logic signed [ValW-1:0]  az;
    logic signed [ValW-1:0]  el;
    logic        [ValW-1:0]  sp;
  } kti_key_t;

  typedef struct packed {
    logic                    found;
    logic signed [TimeW-1:0] ta;
    logic signed [TimeW-1:0] tb;
    logic signed [ValW-1:0]  az_a;
    logic signed [ValW-1:0]  az_b;
    logic signed [ValW-1:0]  el_a;
    logic signed [ValW-1:0]  el_b;
    logic        [ValW-1:0]  sp_a;
    logic        [ValW-1:0]  sp_b;
  } kti_bracket_t;

  // floor((d * u + 32768) / 65536), d up to 18 bits signed, u up to 65536
  function automatic logic signed [ValW+1:0] kti_scale(
      input logic signed [ValW+1:0] d, input logic [FracW-1:0] u);
    logic signed [ValW+FracW+2:0] p;
    begin
      p = d * $signed({1'b0, u});
      p = p + (ValW+FracW+3)'(32768);
      kti_scale = p[ValW+FracW:16];
    end
  endfunction

endpackage

@@ sv/kti_cell.sv @@
// Cell: one keyframe slot that stores its entry and passes the search beat on.
`timescale 1ns / 1ps
module kti_cell
  import kti_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    wr_en_i,
  input  kti_key_t                wr_key_i,
  input  logic                    shift_en_i,
  input  logic                    load_i,
  input  kti_key_t                next_key_i,
  output kti_key_t                key_o,
  output kti_key_t                shift_key_o
);

  kti_key_t store_q;
  kti_key_t shift_q, shift_d;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      store_q <= wr_key_i;
    end
  end

  always_comb begin
    shift_d = shift_q;
    if (load_i) begin
      shift_d = store_q;
    end else if (shift_en_i) begin
      shift_d = next_key_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= '0;
    end else begin
      shift_q <= shift_d;
    end
  end

  assign key_o       = store_q;
  assign shift_key_o = shift_q;

endmodule

@@ sv/kti_div.sv @@
// Divider: restoring unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module kti_div
  import kti_pkg::*;
#(
  parameter int unsigned NumW = 49,
  parameter int unsigned DenW = 33
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic            done_o,
  output logic [NumW-1:0] quo_o,
  output logic [DenW-1:0] rem_o
);

  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [NumW-1:0] quo_q, quo_d;
  logic [DenW-1:0] rem_q, rem_d;
  logic [DenW-1:0] den_q, den_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [DenW:0]   trial;

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, quo_q[NumW-1]} - {1'b0, den_q};
    if (start_i) begin
      quo_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = CntW'(NumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[DenW]) begin
        rem_d = trial[DenW-1:0];
        quo_d = {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[DenW-2:0], quo_q[NumW-1]};
        quo_d = {quo_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

@@ sv/kti_ctrl.sv @@
// Controller: clamp or wrap, bracket search over the cell chain, fraction and blend.
`timescale 1ns / 1ps
module kti_ctrl
  import kti_pkg::*;
#(
  parameter int unsigned MaxKeys = MaxKeysDefault
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [TimeW-1:0] query_time_i,
  input  logic                    loop_enable_i,
  input  logic [CfgDataW-1:0]     key_count_i,
  input  kti_key_t                first_key_i,
  input  kti_key_t                last_key_i,
  input  kti_key_t                head_a_i,
  input  kti_key_t                head_b_i,
  output logic                    load_o,
  output logic                    shift_o,
  output logic                    busy_o,
  output logic                    res_valid_o,
  input  logic                    res_ready_i,
  output logic signed [ValW-1:0]  azimuth_o,
  output logic signed [ValW-1:0]  elevation_o,
  output logic        [ValW-1:0]  spread_o,
  output logic                    table_empty_o
);

  localparam int unsigned IdxW = $clog2(MaxKeys + 1);

  kti_state_e state_q, state_d;
  logic [IdxW-1:0]  n_q, n_d;
  logic [IdxW-1:0]  step_q, step_d;
  logic signed [TimeW:0] t_q, t_d;
  logic signed [TimeW:0] dur_q, dur_d;
  kti_bracket_t br_q, br_d;
  logic [FracW-1:0] u_q, u_d;
  logic signed [ValW-1:0] az_q, az_d, el_q, el_d;
  logic [ValW-1:0] sp_q, sp_d;
  logic emp_q, emp_d;
  logic neg_q, neg_d;
  logic res_valid_q, res_valid_d;
  logic res_load;
  logic signed [ValW-1:0] az_out_q, el_out_q;
  logic [ValW-1:0] sp_out_q;
  logic emp_out_q;

  logic            div_start;
  logic [48:0]     div_num;
  logic [32:0]     div_den;
  logic            div_done;
  logic [48:0]     div_quo;
  logic [32:0]     div_rem;

  logic signed [TimeW:0] t0, t1, ta, tb, off, woff, span;
  logic [IdxW-1:0] n_clip;
  logic signed [ValW+1:0] d_az, d_el, d_sp;
  logic signed [ValW+1:0] s_az, s_el, s_sp;
  logic [ValW-1:0] dazw;

  kti_div #(.NumW(49), .DenW(33)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .done_o (div_done),
    .quo_o  (div_quo),
    .rem_o  (div_rem)
  );

  always_comb begin
    t0   = {first_key_i.t[TimeW-1], first_key_i.t};
    t1   = {last_key_i.t[TimeW-1], last_key_i.t};
    ta   = {head_a_i.t[TimeW-1], head_a_i.t};
    tb   = {head_b_i.t[TimeW-1], head_b_i.t};
    woff = t_q - t0;
    off  = t_q - {br_q.ta[TimeW-1], br_q.ta};
    span = {br_q.tb[TimeW-1], br_q.tb} - {br_q.ta[TimeW-1], br_q.ta};
    n_clip = (32'(key_count_i) > MaxKeys) ? IdxW'(MaxKeys) : IdxW'(key_count_i);
    dazw = br_q.az_b - br_q.az_a;
    d_az = {{2{dazw[ValW-1]}}, dazw};
    d_el = {{2{br_q.el_b[ValW-1]}}, br_q.el_b} - {{2{br_q.el_a[ValW-1]}}, br_q.el_a};
    d_sp = {2'b00, br_q.sp_b} - {2'b00, br_q.sp_a};
    s_az = kti_scale(d_az, u_q);
    s_el = kti_scale(d_el, u_q);
    s_sp = kti_scale(d_sp, u_q);
  end

  always_comb begin
    state_d     = state_q;
    n_d         = n_q;
    step_d      = step_q;
    t_d         = t_q;
    dur_d       = dur_q;
    br_d        = br_q;
    u_d         = u_q;
    az_d        = az_q;
    el_d        = el_q;
    sp_d        = sp_q;
    emp_d       = emp_q;
    neg_d       = neg_q;
    res_valid_d = res_valid_q && !res_ready_i;
    res_load    = 1'b0;
    load_o      = 1'b0;
    shift_o     = 1'b0;
    div_start   = 1'b0;
    div_num     = '0;
    div_den     = '0;
    case (state_q)
      StIdle: begin
        if (start_i) begin
          n_d     = n_clip;
          t_d     = {query_time_i[TimeW-1], query_time_i};
          state_d = StFetch;
        end
      end
      StFetch: begin
        emp_d = 1'b0;
        dur_d = t1 - t0;
        if (n_q == '0) begin
          emp_d = 1'b1; az_d = '0; el_d = '0; sp_d = '0;
          state_d = StDone;
        end else if (n_q == IdxW'(1)) begin
          az_d = first_key_i.az; el_d = first_key_i.el; sp_d = first_key_i.sp;
          state_d = StDone;
        end else if (loop_enable_i && (t1 - t0) > 0) begin
          neg_d     = woff[TimeW];
          div_start = 1'b1;
          div_num   = 49'(woff[TimeW] ? -woff : woff);
          div_den   = 33'(t1 - t0);
          state_d   = StWrapDiv;
        end else if (t_q <= t0) begin
          az_d = first_key_i.az; el_d = first_key_i.el; sp_d = first_key_i.sp;
          state_d = StDone;
        end else if (t_q >= t1) begin
          az_d = last_key_i.az; el_d = last_key_i.el; sp_d = last_key_i.sp;
          state_d = StDone;
        end else begin
          load_o  = 1'b1;
          step_d  = '0;
          br_d.found = 1'b0;
          state_d = StSearch;
        end
      end
      StWrapDiv: begin
        if (div_done) begin
          t_d = {1'b0, div_rem[TimeW-1:0]};
          if (neg_q && div_rem != '0) begin
            t_d = dur_q - $signed({1'b0, div_rem[TimeW-1:0]});
          end
          state_d = StWrapFix;
        end
      end
      StWrapFix: begin
        t_d        = t_q + t0;
        load_o     = 1'b1;
        step_d     = '0;
        br_d.found = 1'b0;
        state_d    = StSearch;
      end
      StSearch: begin
        // walk the chain: head pair advances one slot a cycle
        if (!br_q.found && t_q >= ta && t_q <= tb) begin
          br_d.found = 1'b1;
          br_d.ta = head_a_i.t; br_d.tb = head_b_i.t;
          br_d.az_a = head_a_i.az; br_d.az_b = head_b_i.az;
          br_d.el_a = head_a_i.el; br_d.el_b = head_b_i.el;
          br_d.sp_a = head_a_i.sp; br_d.sp_b = head_b_i.sp;
        end
        shift_o = 1'b1;
        step_d  = step_q + IdxW'(1);
        if (step_q + IdxW'(2) >= n_q) begin
          state_d = StPick;
        end
      end
      StPick: begin
        if (!br_q.found) begin
          az_d = last_key_i.az; el_d = last_key_i.el; sp_d = last_key_i.sp;
          state_d = StDone;
        end else if (span > 0) begin
          div_start = 1'b1;
          div_num   = 49'({off[TimeW-1:0], 16'h0000});
          div_den   = 33'(span);
          state_d   = StFracDiv;
        end else begin
          u_d     = '0;
          state_d = StMul;
        end
      end
      StFracDiv: begin
        if (div_done) begin
          u_d     = div_quo[FracW-1:0];
          state_d = StMul;
        end
      end
      StMul: begin
        az_d = br_q.az_a + s_az[ValW-1:0];
        el_d = br_q.el_a + s_el[ValW-1:0];
        sp_d = br_q.sp_a + s_sp[ValW-1:0];
        state_d = StDone;
      end
      StDone: begin
        // hand over to the output register once it is free
        if (!res_valid_q || res_ready_i) begin
          res_load    = 1'b1;
          res_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      n_q         <= '0;
      step_q      <= '0;
      emp_q       <= 1'b0;
      neg_q       <= 1'b0;
      br_q        <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      n_q         <= n_d;
      step_q      <= step_d;
      emp_q       <= emp_d;
      neg_q       <= neg_d;
      br_q        <= br_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    t_q   <= t_d;
    dur_q <= dur_d;
    u_q   <= u_d;
    az_q  <= az_d;
    el_q  <= el_d;
    sp_q  <= sp_d;
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      az_out_q  <= az_q;
      el_out_q  <= el_q;
      sp_out_q  <= sp_q;
      emp_out_q <= emp_q;
    end
  end

  assign busy_o        = (state_q != StIdle);
  assign res_valid_o   = res_valid_q;
  assign azimuth_o     = az_out_q;
  assign elevation_o   = el_out_q;
  assign spread_o      = sp_out_q;
  assign table_empty_o = emp_out_q;

endmodule

@@ sv/keyframe_trajectory_interpolator_top.sv @@
// Top level: keyframe table as a chain of cells plus the query controller.
`timescale 1ns / 1ps
// Keyframe interpolator. A write beat (opcode 1) stores one keyframe. A query
// beat returns one result through an output register, so the next beat can be
// taken while a result waits. For an empty table, a single keyframe or a
// clamped time the result is set in the fetch state and passed on to the output
// register. Otherwise the controller walks the bracket over the cell chain,
// divides on the one-bit-per-cycle divider for the fraction and blends; loop
// mode first wraps the time on the same divider. One query is in flight at a
// time. The table holds no reset value; read only entries that were written.
module keyframe_trajectory_interpolator_top
  import kti_pkg::*;
#(
  parameter int unsigned MaxKeys = MaxKeysDefault
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CfgAddrW-1:0]     cfg_addr_i,
  input  logic [CfgDataW-1:0]     cfg_wdata_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    opcode_i,
  input  logic [3:0]              key_index_i,
  input  logic signed [TimeW-1:0] key_time_i,
  input  logic signed [ValW-1:0]  key_azimuth_i,
  input  logic signed [ValW-1:0]  key_elevation_i,
  input  logic        [ValW-1:0]  key_spread_i,
  input  logic signed [TimeW-1:0] query_time_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [ValW-1:0]  azimuth_o,
  output logic signed [ValW-1:0]  elevation_o,
  output logic        [ValW-1:0]  spread_o,
  output logic                    table_empty_o
);

  localparam int unsigned IdxW = $clog2(MaxKeys + 1);

  logic                loop_q;
  logic [CfgDataW-1:0] count_q;
  logic                busy, load, shift, accept;
  kti_key_t            wr_key;
  kti_key_t            keys  [MaxKeys];
  kti_key_t            chain [MaxKeys+1];
  kti_key_t            last_key;
  logic [IdxW-1:0]     last_idx;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loop_q  <= 1'b0;
      count_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CfgLoopEnable: loop_q  <= cfg_wdata_i[0];
        CfgKeyCount:   count_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign in_ready_o = !busy;
  assign accept     = in_valid_i && in_ready_o;
  assign wr_key     = '{t: key_time_i, az: key_azimuth_i, el: key_elevation_i,
                        sp: key_spread_i};
  assign chain[MaxKeys] = '0;

  for (genvar g = 0; g < MaxKeys; g++) begin : g_cell
    kti_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .wr_en_i    (accept && opcode_i && (32'(key_index_i) == g)),
      .wr_key_i   (wr_key),
      .shift_en_i (shift),
      .load_i     (load),
      .next_key_i (chain[g+1]),
      .key_o      (keys[g]),
      .shift_key_o(chain[g])
    );
  end

  always_comb begin
    last_idx = (32'(count_q) > MaxKeys) ? IdxW'(MaxKeys - 1)
             : (count_q == '0) ? '0 : IdxW'(count_q - CfgDataW'(1));
    last_key = keys[last_idx[$clog2(MaxKeys)-1:0]];
  end

  kti_ctrl #(.MaxKeys(MaxKeys)) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (accept && !opcode_i),
    .query_time_i (query_time_i),
    .loop_enable_i(loop_q),
    .key_count_i  (count_q),
    .first_key_i  (keys[0]),
    .last_key_i   (last_key),
    .head_a_i     (chain[0]),
    .head_b_i     (chain[1]),
    .load_o       (load),
    .shift_o      (shift),
    .busy_o       (busy),
    .res_valid_o  (out_valid_o),
    .res_ready_i  (out_ready_i),
    .azimuth_o    (azimuth_o),
    .elevation_o  (elevation_o),
    .spread_o     (spread_o),
    .table_empty_o(table_empty_o)
  );

endmodule

@@ sim/tb.sv @@
// Testbench for the keyframe trajectory interpolator: self-checking against its own predictor.
`timescale 1ns / 1ps
module tb;
  import kti_pkg::*;

  typedef enum logic {OpQuery = 1'b0, OpWrite = 1'b1} op_e;

  typedef struct {
    op_e         op;
    logic [3:0]  idx;
    logic [31:0] ktime;
    logic [15:0] kaz;
    logic [15:0] kel;
    logic [15:0] ksp;
    logic [31:0] qtime;
  } beat_t;

  typedef struct {
    logic [15:0] az;
    logic [15:0] el;
    logic [15:0] sp;
    logic        empty;
  } sample_t;

  localparam int NKeys     = 16;
  localparam int SettleCyc = 250;
  localparam int CycLimit  = 3000000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [CfgAddrW-1:0] cfg_addr_i = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        opcode_i = 1'b0;
  logic [3:0]  key_index_i = '0;
  logic signed [31:0] key_time_i = '0;
  logic signed [15:0] key_azimuth_i = '0;
  logic signed [15:0] key_elevation_i = '0;
  logic        [15:0] key_spread_i = '0;
  logic signed [31:0] query_time_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic signed [15:0] azimuth_o;
  logic signed [15:0] elevation_o;
  logic        [15:0] spread_o;
  logic        table_empty_o;

  keyframe_trajectory_interpolator_top dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // predictor state
  logic [31:0] tab_time [NKeys];
  logic [15:0] tab_az [NKeys];
  logic [15:0] tab_el [NKeys];
  logic [15:0] tab_sp [NKeys];
  logic        loop_on = 1'b0;
  logic [4:0]  key_cnt = '0;

  beat_t   pending_beats[$];
  sample_t expected_samples[$];
  beat_t   cur;
  int      errors = 0;
  int      phase_no = 0;
  int      cycles = 0;
  int      hold_left = 0;
  bit      hold_done = 0;

  function automatic longint blend(longint d, longint u);
    return (d * u + 32768) >>> 16;
  endfunction

  function automatic sample_t key_sample(int i);
    sample_t s;
    s.az = tab_az[i];
    s.el = tab_el[i];
    s.sp = tab_sp[i];
    s.empty = 1'b0;
    return s;
  endfunction

  // apply a beat to the table; return 1 with the sample when a query
  function automatic bit interpolate(beat_t b, output sample_t s);
    int n;
    longint t, t0, t1, dur, r, ta, tb, span, u;
    logic signed [15:0] daz;
    s = '{16'h0, 16'h0, 16'h0, 1'b1};
    if (b.op == OpWrite) begin
      tab_time[b.idx] = b.ktime;
      tab_az[b.idx] = b.kaz;
      tab_el[b.idx] = b.kel;
      tab_sp[b.idx] = b.ksp;
      return 0;
    end
    n = (key_cnt > NKeys) ? NKeys : key_cnt;
    if (n == 0) return 1;
    if (n == 1) begin
      s = key_sample(0);
      return 1;
    end
    t = longint'($signed(b.qtime));
    t0 = longint'($signed(tab_time[0]));
    t1 = longint'($signed(tab_time[n-1]));
    dur = t1 - t0;
    if (loop_on && dur > 0) begin
      r = (t - t0) % dur;
      if (r < 0) r += dur;
      t = r + t0;
    end else if (t <= t0) begin
      s = key_sample(0);
      return 1;
    end else if (t >= t1) begin
      s = key_sample(n-1);
      return 1;
    end
    for (int i = 0; i + 1 < n; i++) begin
      ta = longint'($signed(tab_time[i]));
      tb = longint'($signed(tab_time[i+1]));
      if (t >= ta && t <= tb) begin
        span = tb - ta;
        u = (span > 0) ? ((t - ta) << 16) / span : 0;
        daz = tab_az[i+1] - tab_az[i];
        s.az = 16'(longint'($signed(tab_az[i])) + blend(longint'(daz), u));
        s.el = 16'(longint'($signed(tab_el[i])) + blend(longint'($signed(tab_el[i+1]))
               - longint'($signed(tab_el[i])), u));
        s.sp = 16'(longint'(tab_sp[i]) + blend(longint'(tab_sp[i+1]) - longint'(tab_sp[i]), u));
        s.empty = 1'b0;
        return 1;
      end
    end
    s = key_sample(n-1);
    return 1;
  endfunction

  // driver
  always @(posedge clk_i) begin
    sample_t s;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_ready_o) begin
      if (in_valid_i && interpolate(cur, s)) expected_samples.push_back(s);
      if (pending_beats.size() > 0 && (phase_no == 5 || $urandom_range(99) >= 31)) begin
        cur = pending_beats.pop_front();
        in_valid_i <= 1'b1;
        opcode_i <= cur.op;
        key_index_i <= cur.idx;
        key_time_i <= cur.ktime;
        key_azimuth_i <= cur.kaz;
        key_elevation_i <= cur.kel;
        key_spread_i <= cur.ksp;
        query_time_i <= cur.qtime;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    sample_t e;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_samples.size() == 0) begin
          $error("unexpected result beat");
          errors++;
        end else begin
          e = expected_samples.pop_front();
          if (azimuth_o !== e.az) begin
            $error("azimuth exp %0d got %0d", $signed(e.az), azimuth_o);
            errors++;
          end
          if (elevation_o !== e.el) begin
            $error("elevation exp %0d got %0d", $signed(e.el), elevation_o);
            errors++;
          end
          if (spread_o !== e.sp) begin
            $error("spread exp %0d got %0d", e.sp, spread_o);
            errors++;
          end
          if (table_empty_o !== e.empty) begin
            $error("table_empty exp %0d got %0d", e.empty, table_empty_o);
            errors++;
          end
        end
      end
      if (phase_no == 3 && !hold_done) begin
        hold_done <= 1'b1;
        hold_left <= 600;
        out_ready_i <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= (phase_no == 5) || ($urandom_range(99) >= 31);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic wait_idle();
    while (pending_beats.size() > 0 || in_valid_i || expected_samples.size() > 0)
      @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  task automatic set_reg(logic [CfgAddrW-1:0] addr, logic [4:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= addr;
    cfg_wdata_i <= val;
    if (addr == CfgLoopEnable) loop_on = val[0];
    else key_cnt = val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic beat_t rand_beat(op_e op);
    beat_t b;
    b.op = op;
    b.idx = 4'($urandom);
    b.ktime = $urandom;
    b.kaz = 16'($urandom);
    b.kel = 16'($urandom_range(46080) - 23040);
    b.ksp = 16'($urandom);
    b.qtime = $urandom;
    return b;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  task automatic run_phase(bit loop, int cnt, int nq);
    int n, mode;
    longint t, t0, tl, dur, step;
    beat_t b;
    wait_idle();
    set_reg(CfgLoopEnable, 5'(loop));
    set_reg(CfgKeyCount, 5'(cnt));
    n = (cnt > NKeys) ? NKeys : cnt;
    mode = $urandom_range(2);
    t = (mode == 2) ? -64'sd2147483648 + longint'($urandom_range(1000))
                    : longint'($signed(32'($urandom))) >>> $urandom_range(1, 8);
    t0 = t;
    for (int i = 0; i < n; i++) begin
      b = rand_beat(OpWrite);
      b.idx = 4'(i);
      b.ktime = 32'(clamp32(t));
      if ($urandom_range(9) == 0) b.kaz = b.kaz ^ 16'h8000;
      pending_beats.push_back(b);
      tl = clamp32(t);
      step = (mode == 0) ? $urandom_range(50) : (mode == 1) ? $urandom_range(1 << 27)
                                                            : $urandom_range(1 << 28);
      if ($urandom_range(9) == 0) step = 0;
      if ($urandom_range(19) == 0) step = -step;
      t = t + step;
    end
    dur = tl - t0;
    if (dur < 0) dur = -dur;
    for (int q = 0; q < nq; q++) begin
      if ($urandom_range(9) == 0) begin
        pending_beats.push_back(rand_beat(OpWrite));
      end else begin
        b = rand_beat(OpQuery);
        if ($urandom_range(9) < 7)
          b.qtime = 32'(clamp32(t0 - dur / 4 - 20 +
                    longint'({$urandom, $urandom} % (dur * 3 / 2 + 41))));
        pending_beats.push_back(b);
      end
    end
  endtask

  logic [31:0] dir_time [NKeys] = '{32'h80000000, -32'sd1000, 32'sd50, 32'sd50, 32'sd100,
    32'sd3000, 32'sd3001, 32'sd9000, 32'sd100000, 32'sd100000, 32'sd2000000, 32'sd40000000,
    32'sd40000001, 32'sd900000000, 32'sd1500000000, 32'h7fffffff};
  logic [15:0] dir_az [NKeys] = '{16'h0000, 16'h8000, 16'h7fff, 16'h8000, 16'h0001, 16'h8001,
    16'hffff, 16'h7fff, 16'h0000, 16'h4000, 16'hc000, 16'h8000, 16'h0000, 16'h1234,
    16'h9234, 16'h7fff};

  initial begin
    beat_t b;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    // empty table at both time extremes
    b = rand_beat(OpQuery);
    b.qtime = 32'h80000000;
    pending_beats.push_back(b);
    b.qtime = 32'h7fffffff;
    pending_beats.push_back(b);
    for (int i = 0; i < NKeys; i++) begin
      b = rand_beat(OpWrite);
      b.idx = 4'(i);
      b.ktime = dir_time[i];
      b.kaz = dir_az[i];
      b.kel = (i % 2) ? -16'sd23040 : 16'sd23040;
      b.ksp = (i % 2) ? 16'hffff : 16'h0000;
      pending_beats.push_back(b);
    end
    wait_idle();
    set_reg(CfgKeyCount, 5'd16);
    foreach (dir_time[i]) begin
      if (i % 2) continue;
      b = rand_beat(OpQuery);
      b.qtime = dir_time[i] + 32'(i * 7);
      pending_beats.push_back(b);
    end
    run_phase(1'b0, 0, 10);
    run_phase(1'b1, 1, 20);
    phase_no = 3;
    run_phase(1'b1, 16, 40);
    phase_no = 4;
    run_phase(1'b0, 31, 40);
    phase_no = 5;
    run_phase(1'b1, 17, 60);
    phase_no = 6;
    run_phase(1'b0, 2, 30);
    run_phase(1'b1, 2, 30);
    run_phase(1'b0, 1, 10);
    for (int p = 0; p < 16; p++) run_phase(1'(p), $urandom_range(31), 22);
    wait_idle();
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
